// ===== rtl/core/epg_pkg.sv =====
// ----------------------------------------------------------------------------
// epg_pkg
// Shared types and constants for the epicycle point generator: field widths,
// register map, reset values and the phasor type passed out of the lookup.
// ----------------------------------------------------------------------------
package epg_pkg;

   localparam int DEFAULT_PHASE_BITS      = 32;
   localparam int DEFAULT_SINE_TABLE_BITS = 10;

   localparam int STEP_BITS     = 32;
   localparam int RADIUS_BITS   = 15;
   localparam int TRIG_BITS     = 16;
   localparam int TRIG_MAG_BITS = 15;
   localparam int INNER_BITS    = 16;
   localparam int TRACE_BITS    = 17;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 4;

   localparam logic [STEP_BITS-1:0]   INNER_STEP_RESET   = 32'd3417834;
   localparam logic [STEP_BITS-1:0]   OUTER_STEP_RESET   = 32'd10737418;
   localparam logic [RADIUS_BITS-1:0] INNER_RADIUS_RESET = 15'd16384;
   localparam logic [RADIUS_BITS-1:0] OUTER_RADIUS_RESET = 15'd8192;

   localparam logic [63:0] PI_Q40  = 64'h0000_0324_3F6A_8886;
   localparam logic [63:0] ONE_Q30 = 64'h0000_0000_4000_0000;

   typedef enum logic [1:0] {
      REG_INNER_STEP   = 2'd0,
      REG_OUTER_STEP   = 2'd1,
      REG_INNER_RADIUS = 2'd2,
      REG_OUTER_RADIUS = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic signed [TRIG_BITS-1:0] cos_val;
      logic signed [TRIG_BITS-1:0] sin_val;
   } phasor_type;

endpackage

// ===== rtl/core/epg_trig.sv =====
// ----------------------------------------------------------------------------
// epg_trig
// Cosine and sine of one table index, from a quarter-wave sine table built at
// elaboration and folded by quadrant.
// ----------------------------------------------------------------------------
module epg_trig import epg_pkg::*; #(
   parameter int SINE_TABLE_BITS = DEFAULT_SINE_TABLE_BITS
) (
   input  logic [SINE_TABLE_BITS-1:0] index,
   output phasor_type                 phasor
);

   localparam int QBITS = SINE_TABLE_BITS - 2;
   localparam int QT    = 1 << QBITS;
   localparam int AW    = QBITS + 1;

   typedef logic [QT:0][TRIG_MAG_BITS-1:0] qtab_type;

   // Integer quotient by shift and subtract, used only while the table is built.
   function automatic logic [63:0] quotient_of(
      input logic [63:0] num,
      input logic [63:0] den
   );
      logic [63:0] quo;
      logic [64:0] rem;
      quo = '0;
      rem = '0;
      for (int b = 63; b >= 0; b--) begin
         rem = {rem[63:0], num[b]};
         if (rem >= {1'b0, den}) begin
            rem    = rem - {1'b0, den};
            quo[b] = 1'b1;
         end
      end
      return quo;
   endfunction

   // The quarter wave is evaluated with a Q30 Taylor series of eleven terms.
   function automatic qtab_type build_qtab();
      qtab_type          tab;
      logic [63:0]       x;
      logic [63:0]       x2;
      logic [63:0]       term;
      logic [63:0]       div;
      logic [63:0]       rnd;
      logic signed [63:0] sum;
      for (int q = 0; q <= QT; q++) begin
         x    = (64'(q) * PI_Q40) >> (SINE_TABLE_BITS + 9);
         x2   = (x * x) >> 30;
         term = x;
         sum  = signed'(x);
         for (int n = 1; n <= 10; n++) begin
            term = (term * x2) >> 30;
            div  = 64'((2 * n) * (2 * n + 1));
            term = quotient_of(term, div);
            if ((n & 1) == 1) begin
               sum = sum - signed'(term);
            end else begin
               sum = sum + signed'(term);
            end
         end
         if (sum < 0) begin
            sum = 64'sd0;
         end
         if (sum > signed'(ONE_Q30)) begin
            sum = signed'(ONE_Q30);
         end
         rnd    = ((64'(sum) * 64'd32767) + (64'd1 << 29)) >> 30;
         tab[q] = rnd[TRIG_MAG_BITS-1:0];
      end
      return tab;
   endfunction

   localparam qtab_type QTAB = build_qtab();

   function automatic logic signed [TRIG_BITS-1:0] sine_of(
      input logic [SINE_TABLE_BITS-1:0] k
   );
      logic [1:0]               quadrant;
      logic [AW-1:0]            offset;
      logic [AW-1:0]            addr;
      logic [TRIG_MAG_BITS-1:0] mag;
      quadrant = k[SINE_TABLE_BITS-1 -: 2];
      offset   = {1'b0, k[QBITS-1:0]};
      addr     = quadrant[0] ? (AW'(QT) - offset) : offset;
      mag      = QTAB[addr];
      return quadrant[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
   endfunction

   assign phasor.sin_val = sine_of(index);
   assign phasor.cos_val = sine_of(index + SINE_TABLE_BITS'(QT));

endmodule

// ===== rtl/core/epicycle_point_generator.sv =====
// ----------------------------------------------------------------------------
// epicycle_point_generator
// Two phase accumulators drive two rotating arms; each transaction gives the
// tip of the inner arm and the traced point at the end of the outer arm.
//
//   Channel  Direction  Ports                     Contents
//   req      in         req_valid/req_ready       advance
//   rsp      out        rsp_valid/rsp_ready       inner_x, inner_y, trace_x, trace_y
//   csr      in/out     psel/penable/pwrite/...   phase steps and arm radii
//
// One transaction is accepted per cycle while the result side is not stalled;
// a result passes in turn through the index, lookup, scaling and summing stages.
// The phases advance at acceptance of an advancing request, in request order.
// Each stage moves on whenever the stage after it is empty or moving, so a
// stalled result only holds back the stages behind it.
// Reset clears the phases and stage valid flags and sets the registers to reset values.
// ----------------------------------------------------------------------------
module epicycle_point_generator import epg_pkg::*; #(
   parameter int PHASE_BITS      = DEFAULT_PHASE_BITS,
   parameter int SINE_TABLE_BITS = DEFAULT_SINE_TABLE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_advance,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic signed [INNER_BITS-1:0]  rsp_inner_x,
   output logic signed [INNER_BITS-1:0]  rsp_inner_y,
   output logic signed [TRACE_BITS-1:0]  rsp_trace_x,
   output logic signed [TRACE_BITS-1:0]  rsp_trace_y,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [CSR_ADDR_BITS-1:0]      paddr,
   input  logic [CSR_DATA_BITS-1:0]      pwdata,
   output logic [CSR_DATA_BITS-1:0]      prdata,
   output logic                          pready
);

   logic [STEP_BITS-1:0]   inner_step_ff;
   logic [STEP_BITS-1:0]   outer_step_ff;
   logic [RADIUS_BITS-1:0] inner_radius_ff;
   logic [RADIUS_BITS-1:0] outer_radius_ff;
   reg_index_type          reg_index;
   logic                   csr_write;

   logic [PHASE_BITS-1:0]  inner_phase_ff;
   logic [PHASE_BITS-1:0]  outer_phase_ff;
   logic [PHASE_BITS-1:0]  inner_phase_in;
   logic [PHASE_BITS-1:0]  outer_phase_in;
   logic [PHASE_BITS-1:0]  inner_step_aligned;
   logic [PHASE_BITS-1:0]  outer_step_aligned;
   logic [63:0]            inner_step_wide;
   logic [63:0]            outer_step_wide;

   logic                   req_accept;
   logic                   out_en;
   logic                   s3_en;
   logic                   s2_en;
   logic                   s1_en;

   logic                        s1_valid_ff;
   logic [SINE_TABLE_BITS-1:0]  s1_inner_idx_ff;
   logic [SINE_TABLE_BITS-1:0]  s1_outer_idx_ff;

   phasor_type             inner_phasor;
   phasor_type             outer_phasor;
   logic                   s2_valid_ff;
   phasor_type             s2_inner_ff;
   phasor_type             s2_outer_ff;

   logic                         s3_valid_ff;
   logic signed [INNER_BITS-1:0] s3_inner_x_ff;
   logic signed [INNER_BITS-1:0] s3_inner_y_ff;
   logic signed [INNER_BITS-1:0] s3_outer_x_ff;
   logic signed [INNER_BITS-1:0] s3_outer_y_ff;

   logic                         rsp_valid_ff;
   logic signed [INNER_BITS-1:0] rsp_inner_x_ff;
   logic signed [INNER_BITS-1:0] rsp_inner_y_ff;
   logic signed [TRACE_BITS-1:0] rsp_trace_x_ff;
   logic signed [TRACE_BITS-1:0] rsp_trace_y_ff;

   // Radius in Q0.15 times a Q1.15 value, rounded half up back to Q1.15.
   function automatic logic signed [INNER_BITS-1:0] scale(
      input logic [RADIUS_BITS-1:0]      radius,
      input logic signed [TRIG_BITS-1:0] trig
   );
      logic signed [31:0] prod;
      logic signed [31:0] rounded;
      prod    = $signed({1'b0, radius}) * trig;
      rounded = (prod + 32'sd16384) >>> 15;
      return rounded[INNER_BITS-1:0];
   endfunction

   // Configuration registers.
   assign pready    = 1'b1;
   assign reg_index = reg_index_type'(paddr[3:2]);
   assign csr_write = psel & penable & pwrite & pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_step_ff   <= INNER_STEP_RESET;
         outer_step_ff   <= OUTER_STEP_RESET;
         inner_radius_ff <= INNER_RADIUS_RESET;
         outer_radius_ff <= OUTER_RADIUS_RESET;
      end else if (csr_write) begin
         unique case (reg_index)
            REG_INNER_STEP:   inner_step_ff   <= pwdata;
            REG_OUTER_STEP:   outer_step_ff   <= pwdata;
            REG_INNER_RADIUS: inner_radius_ff <= pwdata[RADIUS_BITS-1:0];
            REG_OUTER_RADIUS: outer_radius_ff <= pwdata[RADIUS_BITS-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_index)
         REG_INNER_STEP:   prdata = inner_step_ff;
         REG_OUTER_STEP:   prdata = outer_step_ff;
         REG_INNER_RADIUS: prdata = CSR_DATA_BITS'(inner_radius_ff);
         REG_OUTER_RADIUS: prdata = CSR_DATA_BITS'(outer_radius_ff);
      endcase
   end

   // Stage enables: a stage moves when the one after it is empty or moving.
   assign out_en     = !rsp_valid_ff || rsp_ready;
   assign s3_en      = !s3_valid_ff || out_en;
   assign s2_en      = !s2_valid_ff || s3_en;
   assign s1_en      = !s1_valid_ff || s2_en;
   assign req_ready  = s1_en;
   assign req_accept = req_valid && req_ready;

   // The step sits at the top of the phase word.
   assign inner_step_wide    = {inner_step_ff, 32'd0};
   assign outer_step_wide    = {outer_step_ff, 32'd0};
   assign inner_step_aligned = inner_step_wide[63 -: PHASE_BITS];
   assign outer_step_aligned = outer_step_wide[63 -: PHASE_BITS];

   always_comb begin
      inner_phase_in = inner_phase_ff;
      outer_phase_in = outer_phase_ff;
      if (req_accept && req_advance) begin
         inner_phase_in = inner_phase_ff + inner_step_aligned;
         outer_phase_in = outer_phase_ff + outer_step_aligned;
      end
   end

   epg_trig #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_inner_trig (
      .index  (s1_inner_idx_ff),
      .phasor (inner_phasor)
   );

   epg_trig #(
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_outer_trig (
      .index  (s1_outer_idx_ff),
      .phasor (outer_phasor)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_phase_ff <= '0;
         outer_phase_ff <= '0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s3_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         inner_phase_ff <= inner_phase_in;
         outer_phase_ff <= outer_phase_in;
         if (s1_en) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_en) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_en) begin
            s3_valid_ff <= s2_valid_ff;
         end
         if (out_en) begin
            rsp_valid_ff <= s3_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_inner_idx_ff <= inner_phase_in[PHASE_BITS-1 -: SINE_TABLE_BITS];
         s1_outer_idx_ff <= outer_phase_in[PHASE_BITS-1 -: SINE_TABLE_BITS];
      end
      if (s2_en) begin
         s2_inner_ff <= inner_phasor;
         s2_outer_ff <= outer_phasor;
      end
      if (s3_en) begin
         s3_inner_x_ff <= scale(inner_radius_ff, s2_inner_ff.cos_val);
         s3_inner_y_ff <= scale(inner_radius_ff, s2_inner_ff.sin_val);
         s3_outer_x_ff <= scale(outer_radius_ff, s2_outer_ff.cos_val);
         s3_outer_y_ff <= scale(outer_radius_ff, s2_outer_ff.sin_val);
      end
      if (out_en) begin
         rsp_inner_x_ff <= s3_inner_x_ff;
         rsp_inner_y_ff <= s3_inner_y_ff;
         rsp_trace_x_ff <= TRACE_BITS'(s3_inner_x_ff) + TRACE_BITS'(s3_outer_x_ff);
         rsp_trace_y_ff <= TRACE_BITS'(s3_inner_y_ff) + TRACE_BITS'(s3_outer_y_ff);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_inner_x = rsp_inner_x_ff;
   assign rsp_inner_y = rsp_inner_y_ff;
   assign rsp_trace_x = rsp_trace_x_ff;
   assign rsp_trace_y = rsp_trace_y_ff;

   // The phases move only on a transaction that asks to advance.
   a_phase_hold: assert property (@(posedge clock) disable iff (reset)
      !(req_accept && req_advance) |=>
         $stable(inner_phase_ff) && $stable(outer_phase_ff))
      else $error("phase changed without an advancing transaction");

   // An empty result stage always leaves the request side open.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid_ff |-> req_ready)
      else $error("request blocked with an empty result register");

   // Table values never reach the negative full-scale code.
   a_trig_range: assert property (@(posedge clock) disable iff (reset)
      s2_valid_ff |-> (s2_inner_ff.cos_val != -16'sd32768) &&
                      (s2_inner_ff.sin_val != -16'sd32768) &&
                      (s2_outer_ff.cos_val != -16'sd32768) &&
                      (s2_outer_ff.sin_val != -16'sd32768))
      else $error("trig value out of range");

   // A stalled scaling stage keeps its contents.
   a_s3_hold: assert property (@(posedge clock) disable iff (reset)
      s3_valid_ff && !s3_en |=> s3_valid_ff && $stable(s3_inner_x_ff) &&
                                 $stable(s3_outer_y_ff))
      else $error("scaling stage lost a stalled transaction");

endmodule

// ===== test/epicycle_point_generator_tb.sv =====
// ----------------------------------------------------------------------------
// epicycle_point_generator_tb
// Self-checking bench for the epicycle point generator. A scoreboard keeps its
// own copy of the phases, steps and radii, builds the sine table from a fixed
// point series and predicts the inner tip and traced point of every accepted
// request transaction. Results are compared field by field in order. Directed
// transactions cover the quadrant boundaries and extreme settings, then random
// phases with new register settings run, most with random gaps on both channels,
// including one long result hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
module epicycle_point_generator_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import epg_pkg::*;

   localparam int PHASE_W    = DEFAULT_PHASE_BITS;
   localparam int TABLE_W    = DEFAULT_SINE_TABLE_BITS;
   localparam int TABLE_SIZE = 1 << TABLE_W;

   typedef struct {
      logic signed [INNER_BITS-1:0] inner_x;
      logic signed [INNER_BITS-1:0] inner_y;
      logic signed [TRACE_BITS-1:0] trace_x;
      logic signed [TRACE_BITS-1:0] trace_y;
   } arm_point_type;

   class epicycle_tracker;
      logic [STEP_BITS-1:0]   inner_step;
      logic [STEP_BITS-1:0]   outer_step;
      logic [RADIUS_BITS-1:0] inner_radius;
      logic [RADIUS_BITS-1:0] outer_radius;
      longint unsigned        inner_phase;
      longint unsigned        outer_phase;
      int                     sine_rom[TABLE_SIZE];
      arm_point_type          pending_points[$];
      int                     errors;

      function new();
         for (int k = 0; k < TABLE_SIZE; k++) begin
            sine_rom[k] = table_entry(k);
         end
         inner_step   = INNER_STEP_RESET;
         outer_step   = OUTER_STEP_RESET;
         inner_radius = INNER_RADIUS_RESET;
         outer_radius = OUTER_RADIUS_RESET;
         inner_phase  = 0;
         outer_phase  = 0;
         errors       = 0;
      endfunction

      function int quarter_wave(longint unsigned q);
         longint unsigned x;
         longint unsigned x2;
         longint unsigned term;
         longint          sum;
         longint unsigned usum;
         x    = (q * PI_Q40) >> (TABLE_W + 9);
         x2   = (x * x) >> 30;
         term = x;
         sum  = longint'(x);
         for (longint unsigned n = 1; n <= 10; n++) begin
            term = (term * x2) >> 30;
            term = term / ((2 * n) * (2 * n + 1));
            if (n % 2 == 1) begin
               sum = sum - longint'(term);
            end else begin
               sum = sum + longint'(term);
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         if (sum > longint'(ONE_Q30)) begin
            sum = longint'(ONE_Q30);
         end
         usum = sum;
         return int'((usum * 32767 + (64'd1 << 29)) >> 30);
      endfunction

      function int table_entry(int k);
         int half;
         int qt;
         half = TABLE_SIZE / 2;
         qt   = TABLE_SIZE / 4;
         if (k <= qt) begin
            return quarter_wave(k);
         end
         if (k < half) begin
            return quarter_wave(half - k);
         end
         if (k <= half + qt) begin
            return -quarter_wave(k - half);
         end
         return -quarter_wave(TABLE_SIZE - k);
      endfunction

      function longint unsigned phase_mask();
         return (PHASE_W >= 64) ? ~64'd0 : ((64'd1 << PHASE_W) - 1);
      endfunction

      function longint unsigned aligned_step(logic [STEP_BITS-1:0] step);
         longint unsigned v;
         v = step;
         if (PHASE_W >= 32) begin
            return (v << (PHASE_W - 32)) & phase_mask();
         end
         return v >> (32 - PHASE_W);
      endfunction

      function int arm_term(logic [RADIUS_BITS-1:0] radius, int trig);
         longint p;
         p = longint'(radius) * trig + 16384;
         return int'(p >>> 15);
      endfunction

      function void set_register(reg_index_type idx, logic [31:0] value);
         case (idx)
            REG_INNER_STEP:   inner_step   = value;
            REG_OUTER_STEP:   outer_step   = value;
            REG_INNER_RADIUS: inner_radius = value[RADIUS_BITS-1:0];
            REG_OUTER_RADIUS: outer_radius = value[RADIUS_BITS-1:0];
            default: ;
         endcase
      endfunction

      function logic [31:0] register_value(reg_index_type idx);
         case (idx)
            REG_INNER_STEP:   return inner_step;
            REG_OUTER_STEP:   return outer_step;
            REG_INNER_RADIUS: return 32'(inner_radius);
            default:          return 32'(outer_radius);
         endcase
      endfunction

      function void note_request(logic advance);
         arm_point_type   pt;
         longint unsigned ki;
         longint unsigned ko;
         int              ix;
         int              iy;
         int              tx;
         int              ty;
         if (advance) begin
            inner_phase = (inner_phase + aligned_step(inner_step)) & phase_mask();
            outer_phase = (outer_phase + aligned_step(outer_step)) & phase_mask();
         end
         ki = (inner_phase & phase_mask()) >> (PHASE_W - TABLE_W);
         ko = (outer_phase & phase_mask()) >> (PHASE_W - TABLE_W);
         ix = arm_term(inner_radius, sine_rom[(ki + TABLE_SIZE / 4) % TABLE_SIZE]);
         iy = arm_term(inner_radius, sine_rom[ki]);
         tx = ix + arm_term(outer_radius, sine_rom[(ko + TABLE_SIZE / 4) % TABLE_SIZE]);
         ty = iy + arm_term(outer_radius, sine_rom[ko]);
         pt.inner_x = ix[INNER_BITS-1:0];
         pt.inner_y = iy[INNER_BITS-1:0];
         pt.trace_x = tx[TRACE_BITS-1:0];
         pt.trace_y = ty[TRACE_BITS-1:0];
         pending_points.push_back(pt);
      endfunction

      function void check_point(logic signed [INNER_BITS-1:0] ix,
                                logic signed [INNER_BITS-1:0] iy,
                                logic signed [TRACE_BITS-1:0] tx,
                                logic signed [TRACE_BITS-1:0] ty);
         arm_point_type want;
         if (pending_points.size() == 0) begin
            report("result transaction with no point outstanding");
            return;
         end
         want = pending_points.pop_front();
         if (ix !== want.inner_x) begin
            report($sformatf("inner_x got %0d wanted %0d", ix, want.inner_x));
         end
         if (iy !== want.inner_y) begin
            report($sformatf("inner_y got %0d wanted %0d", iy, want.inner_y));
         end
         if (tx !== want.trace_x) begin
            report($sformatf("trace_x got %0d wanted %0d", tx, want.trace_x));
         end
         if (ty !== want.trace_y) begin
            report($sformatf("trace_y got %0d wanted %0d", ty, want.trace_y));
         end
      endfunction

      function void report(string what);
         $display("%0t ns mismatch: %s", $time, what);
         errors++;
      endfunction
   endclass

   logic                          clock = 1'b0;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic                          req_advance;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic signed [INNER_BITS-1:0]  rsp_inner_x;
   logic signed [INNER_BITS-1:0]  rsp_inner_y;
   logic signed [TRACE_BITS-1:0]  rsp_trace_x;
   logic signed [TRACE_BITS-1:0]  rsp_trace_y;
   logic                          psel;
   logic                          penable;
   logic                          pwrite;
   logic [CSR_ADDR_BITS-1:0]      paddr;
   logic [CSR_DATA_BITS-1:0]      pwdata;
   logic [CSR_DATA_BITS-1:0]      prdata;
   logic                          pready;

   epicycle_tracker tracker;
   bit              idling_on;
   bit              hold_request;

   epicycle_point_generator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_advance (req_advance),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_inner_x (rsp_inner_x),
      .rsp_inner_y (rsp_inner_y),
      .rsp_trace_x (rsp_trace_x),
      .rsp_trace_y (rsp_trace_y),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready)
   );

   always #6ns clock = ~clock;

   function automatic int pick_gap();
      int r;
      if (!idling_on) begin
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   function automatic logic [31:0] random_step();
      case ($urandom_range(0, 5))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return $urandom_range(0, 32'h00FF_FFFF);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [31:0] random_radius();
      case ($urandom_range(0, 4))
         0:       return 32'd0;
         1:       return 32'd32767;
         default: return $urandom;
      endcase
   endfunction

   task automatic write_register(reg_index_type idx, logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= CSR_ADDR_BITS'(int'(idx) * 4);
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      tracker.set_register(idx, value);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      if (prdata !== tracker.register_value(idx)) begin
         tracker.report($sformatf("register %s read %h wanted %h", idx.name(), prdata,
                                  tracker.register_value(idx)));
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic configure(logic [31:0] in_step, logic [31:0] out_step,
                            logic [31:0] in_radius, logic [31:0] out_radius);
      write_register(REG_INNER_STEP, in_step);
      write_register(REG_OUTER_STEP, out_step);
      write_register(REG_INNER_RADIUS, in_radius);
      write_register(REG_OUTER_RADIUS, out_radius);
   endtask

   task automatic send_transaction(logic advance);
      int gap;
      req_valid   <= 1'b1;
      req_advance <= advance;
      do @(posedge clock); while (req_ready !== 1'b1);
      tracker.note_request(advance);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (tracker.pending_points.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   initial begin : result_side
      int stall;
      stall     = 0;
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
            tracker.check_point(rsp_inner_x, rsp_inner_y, rsp_trace_x, rsp_trace_y);
         end
         if (hold_request) begin
            stall        = 150;
            hold_request = 1'b0;
         end else if (stall == 0 && $urandom_range(0, 5) == 0) begin
            stall = pick_gap();
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            stall--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      tracker      = new();
      idling_on    = 1'b1;
      hold_request = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_advance  = 1'b0;
      psel         = 1'b0;
      penable      = 1'b0;
      pwrite       = 1'b0;
      paddr        = '0;
      pwdata       = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_transaction(1'b0);
      send_transaction(1'b0);
      repeat (3) send_transaction(1'b1);
      drain();

      configure(32'h4000_0000, 32'h8000_0000, 32'd32767, 32'd32767);
      send_transaction(1'b0);
      repeat (5) send_transaction(1'b1);
      drain();

      configure(32'hFFFF_FFFF, 32'h0000_0000, 32'd0, 32'd32767);
      repeat (4) send_transaction(1'b1);
      send_transaction(1'b0);
      drain();

      configure(32'h0040_0000, 32'hFFC0_0000, 32'hFFFF_8001, 32'h0000_7FFF);
      repeat (5) send_transaction(1'b1);
      drain();

      for (int phase_no = 0; phase_no < 6; phase_no++) begin
         configure(random_step(), random_step(), random_radius(), random_radius());
         idling_on = (phase_no % 3 != 1);
         for (int i = 0; i < 310; i++) begin
            if (phase_no == 1 && i == 40) begin
               hold_request = 1'b1;
            end
            send_transaction($urandom_range(0, 9) < 8);
         end
         drain();
      end

      if (tracker.errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin : watchdog
      #15ms;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/epg_pkg.sv
rtl/core/epg_trig.sv
rtl/core/epicycle_point_generator.sv
test/epicycle_point_generator_tb.sv
